[rtl/core/sctd_pkg.sv]
`default_nettype none

package sctd_pkg;

  // Pipeline depth, from the input register to the output register.
  localparam int unsigned NumStages = 9;

  // 86400 = 2^7 * 675. The shift is taken first and the quotient by 675 is
  // estimated with a truncated reciprocal, then corrected by one compare.
  localparam int unsigned DaySecShift = 7;
  localparam logic [9:0]  DAY_DIV_ODD = 10'd675;
  localparam logic [22:0] RECIP_675   = 23'd6362914;  // floor(2^32 / 675)

  // Unix day numbers at which the 1 March based century changes
  // (1 March 2000 and 1 March 2100), and the day offset into the
  // century that starts on 1 March 1900.
  localparam logic [15:0] DAY_CENT_2000 = 16'd11017;
  localparam logic [15:0] DAY_CENT_2100 = 16'd47541;
  localparam logic [15:0] DAY_OFS_1900  = 16'd25508;

  // Exact reciprocals: floor(n * M / 2^k) equals floor(n / d) over the
  // range of n that reaches each divider.
  localparam logic [17:0] RECIP_1461 = 18'd183735;   // k = 28
  localparam logic [12:0] RECIP_153  = 13'd6854;     // k = 20
  localparam logic [17:0] RECIP_3600 = 18'd149131;   // k = 29
  localparam logic [12:0] RECIP_60   = 13'd4370;     // k = 18

  localparam logic [17:0] YEAR_GRP_BIAS = 18'd1464;  // 4 * 366
  localparam logic [8:0]  DAYS_YEAR     = 9'd365;
  localparam logic [11:0] SECS_HOUR     = 12'd3600;
  localparam logic [5:0]  SECS_MINUTE   = 6'd60;

  // Century index: 0 for 1900, 1 for 2000, 2 for 2100.
  typedef logic [1:0] cent_t;

  localparam cent_t CENT_1900 = 2'd0;
  localparam cent_t CENT_2000 = 2'd1;
  localparam cent_t CENT_2100 = 2'd2;

  function automatic logic [11:0] cent_year(input cent_t c);
    logic [11:0] y;
    case (c)
      CENT_2000: y = 12'd2000;
      CENT_2100: y = 12'd2100;
      default:   y = 12'd1900;
    endcase
    return y;
  endfunction

  // First day of each month counted from 1 March: (153 * m + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  // Month index from which the month falls into the next calendar year.
  localparam logic [3:0] MONTH_JAN = 4'd10;

  // Load enables of the pipeline stages, bit 0 is the first stage.
  typedef logic [NumStages-1:0] stage_en_t;

endpackage

`default_nettype wire

[rtl/core/sctd_day_split.sv]
`default_nettype none

// Stages one to four: epoch add, then Unix seconds split into day number and
// second of day.
module sctd_day_split (
  input  logic        clk_i,
  input  logic [3:0]  en_i,
  input  logic [31:0] time_seconds_i,
  input  logic [31:0] epoch_offset_i,
  output logic [15:0] day_num_o,
  output logic [16:0] sod_o
);

  logic [31:0] unix_q;
  logic [24:0] x2_q;
  logic [6:0]  lo2_q;
  logic [47:0] p1_q;
  logic [24:0] x3_q;
  logic [6:0]  lo3_q;
  logic [15:0] q0_q;
  logic [24:0] p2_q;
  logic [15:0] day_q;
  logic [16:0] sod_q;

  logic [15:0] q0_d;
  logic [25:0] p2_full;
  logic [24:0] diff;
  logic [10:0] rem;
  logic        over;
  logic [10:0] rem_adj;

  assign q0_d    = p1_q[47:32];
  assign p2_full = 26'(q0_d) * 26'(sctd_pkg::DAY_DIV_ODD);
  assign diff    = x3_q - p2_q;
  assign rem     = diff[10:0];
  assign over    = (rem >= 11'(sctd_pkg::DAY_DIV_ODD));
  assign rem_adj = over ? 11'(rem - 11'(sctd_pkg::DAY_DIV_ODD)) : rem;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      unix_q <= 32'(time_seconds_i + epoch_offset_i);
    end
    if (en_i[1]) begin
      x2_q  <= unix_q[31:sctd_pkg::DaySecShift];
      lo2_q <= unix_q[sctd_pkg::DaySecShift-1:0];
      p1_q  <= 48'(unix_q[31:sctd_pkg::DaySecShift]) * 48'(sctd_pkg::RECIP_675);
    end
    if (en_i[2]) begin
      x3_q  <= x2_q;
      lo3_q <= lo2_q;
      q0_q  <= q0_d;
      p2_q  <= p2_full[24:0];
    end
    if (en_i[3]) begin
      day_q <= over ? 16'(q0_q + 16'd1) : q0_q;
      sod_q <= {rem_adj[9:0], lo3_q};
    end
  end

  assign day_num_o = day_q;
  assign sod_o     = sod_q;

endmodule

`default_nettype wire

[rtl/core/sctd_tod.sv]
`default_nettype none

// Stages five to nine: second of day into hour, minute and second.
module sctd_tod (
  input  logic        clk_i,
  input  logic [4:0]  en_i,
  input  logic [16:0] sod_i,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  logic [16:0] sod5_q;
  logic [34:0] ph_q;
  logic [16:0] sod6_q;
  logic [4:0]  hour6_q;
  logic [16:0] hp_q;
  logic [4:0]  hour7_q;
  logic [11:0] rem7_q;
  logic [24:0] pm_q;
  logic [4:0]  hour8_q;
  logic [5:0]  min8_q;
  logic [5:0]  sec8_q;
  logic [4:0]  hour9_q;
  logic [5:0]  min9_q;
  logic [5:0]  sec9_q;

  logic [4:0]  hour_d;
  logic [16:0] hp_d;
  logic [16:0] rem_full;
  logic [5:0]  min_d;
  logic [11:0] min_secs;
  logic [11:0] sec_full;

  assign hour_d   = ph_q[33:29];
  assign hp_d     = 17'(hour_d) * 17'(sctd_pkg::SECS_HOUR);
  assign rem_full = sod6_q - hp_q;
  assign min_d    = pm_q[23:18];
  assign min_secs = 12'(min_d) * 12'(sctd_pkg::SECS_MINUTE);
  assign sec_full = rem7_q - min_secs;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sod5_q <= sod_i;
      ph_q   <= 35'(sod_i) * 35'(sctd_pkg::RECIP_3600);
    end
    if (en_i[1]) begin
      sod6_q  <= sod5_q;
      hour6_q <= hour_d;
      hp_q    <= hp_d;
    end
    if (en_i[2]) begin
      hour7_q <= hour6_q;
      rem7_q  <= rem_full[11:0];
      pm_q    <= 25'(rem_full[11:0]) * 25'(sctd_pkg::RECIP_60);
    end
    if (en_i[3]) begin
      hour8_q <= hour7_q;
      min8_q  <= min_d;
      sec8_q  <= sec_full[5:0];
    end
    if (en_i[4]) begin
      hour9_q <= hour8_q;
      min9_q  <= min8_q;
      sec9_q  <= sec8_q;
    end
  end

  assign hour_o   = hour9_q;
  assign minute_o = min9_q;
  assign second_o = sec9_q;

endmodule

`default_nettype wire

[rtl/core/sctd_date.sv]
`default_nettype none

// Stages five to nine: Unix day number into Gregorian year, month and day.
// The year runs from 1 March, so January and February close the year.
module sctd_date (
  input  logic        clk_i,
  input  logic [4:0]  en_i,
  input  logic [15:0] day_num_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o
);

  sctd_pkg::cent_t cent5_q, cent6_q, cent7_q, cent8_q;
  logic [15:0] days5_q;
  logic [15:0] days6_q;
  logic [35:0] py_q;
  logic [15:0] days7_q;
  logic [6:0]  t2_7_q;
  logic [15:0] yd_q;
  logic [6:0]  t2_8_q;
  logic [8:0]  days8_q;
  logic [23:0] pmo_q;
  logic [11:0] year9_q;
  logic [3:0]  month9_q;
  logic [4:0]  day9_q;

  sctd_pkg::cent_t cent_d;
  logic [16:0] days2_full;
  logic [17:0] grp_num;
  logic [6:0]  t2_d;
  logic [15:0] yd_d;
  logic [15:0] days3_full;
  logic [10:0] mnum;
  logic [3:0]  midx;
  logic        wrap;
  logic [8:0]  mday_full;

  // Century from the day number, then the day within that century.
  always_comb begin
    if (day_num_i >= sctd_pkg::DAY_CENT_2100) begin
      cent_d     = sctd_pkg::CENT_2100;
      days2_full = 17'(day_num_i) - 17'(sctd_pkg::DAY_CENT_2100);
    end else if (day_num_i >= sctd_pkg::DAY_CENT_2000) begin
      cent_d     = sctd_pkg::CENT_2000;
      days2_full = 17'(day_num_i) - 17'(sctd_pkg::DAY_CENT_2000);
    end else begin
      cent_d     = sctd_pkg::CENT_1900;
      days2_full = 17'(day_num_i) + 17'(sctd_pkg::DAY_OFS_1900);
    end
  end

  assign grp_num    = {days5_q, 2'b00} + sctd_pkg::YEAR_GRP_BIAS;
  assign t2_d       = 7'(py_q[34:28] - 7'd1);
  assign yd_d       = 16'(16'(t2_d) * 16'(sctd_pkg::DAYS_YEAR)) + 16'(t2_d >> 2);
  assign days3_full = days7_q - yd_q;
  assign mnum       = 11'(11'(days3_full[8:0]) * 11'd5) + 11'd2;
  assign midx       = pmo_q[23:20];
  assign wrap       = (midx >= sctd_pkg::MONTH_JAN);
  assign mday_full  = 9'(days8_q - sctd_pkg::month_start(midx) + 9'd1);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      cent5_q <= cent_d;
      days5_q <= days2_full[15:0];
    end
    if (en_i[1]) begin
      cent6_q <= cent5_q;
      days6_q <= days5_q;
      py_q    <= 36'(grp_num) * 36'(sctd_pkg::RECIP_1461);
    end
    if (en_i[2]) begin
      cent7_q <= cent6_q;
      days7_q <= days6_q;
      t2_7_q  <= t2_d;
      yd_q    <= yd_d;
    end
    if (en_i[3]) begin
      cent8_q <= cent7_q;
      t2_8_q  <= t2_7_q;
      days8_q <= days3_full[8:0];
      pmo_q   <= 24'(mnum) * 24'(sctd_pkg::RECIP_153);
    end
    if (en_i[4]) begin
      year9_q  <= sctd_pkg::cent_year(cent8_q) + 12'(t2_8_q) + 12'(wrap);
      month9_q <= wrap ? 4'(midx - 4'd9) : 4'(midx + 4'd3);
      day9_q   <= mday_full[4:0];
    end
  end

  assign year_o  = year9_q;
  assign month_o = month9_q;
  assign day_o   = day9_q;

endmodule

`default_nettype wire

[rtl/core/seconds_to_calendar_date.sv]
`default_nettype none

// Channel    | Direction | Handshake             | Word
// -----------+-----------+-----------------------+-------------------------------
// input      | in        | in_valid_i/in_ready_o | time_seconds_i
// result     | out       | out_valid_o/out_ready_i | year_o month_o day_o hour_o
//            |           |                       | minute_o second_o
// config     | in        | cfg_we_i              | cfg_wdata_i (epoch offset)
//
// One word enters per cycle while in_ready_o is high; the pipeline has nine
// register stages. Reset clears the stage valid bits and sets the epoch
// offset to zero. A stall at the output backs up only as far as the first
// empty stage, so bubbles are squeezed out and a new word is taken while a
// result waits, as long as some stage is empty.
module seconds_to_calendar_date (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] time_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);

  localparam int unsigned N = sctd_pkg::NumStages;

  logic [31:0] epoch_offset_q;
  logic [N-1:0] valid_q;
  logic [N-1:0] valid_d;
  sctd_pkg::stage_en_t en;
  logic [15:0] day_num;
  logic [16:0] sod;

  // The user must change the epoch offset only while the pipeline is empty; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_offset_q <= '0;
    end else if (cfg_we_i) begin
      epoch_offset_q <= cfg_wdata_i;
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[N-1] = ~valid_q[N-1] | out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      en[k] = ~valid_q[k] | en[k+1];
    end
    valid_d[0] = en[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < N; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[N-1];

  sctd_day_split u_split (
    .clk_i          (clk_i),
    .en_i           (en[3:0]),
    .time_seconds_i (time_seconds_i),
    .epoch_offset_i (epoch_offset_q),
    .day_num_o      (day_num),
    .sod_o          (sod)
  );

  sctd_date u_date (
    .clk_i     (clk_i),
    .en_i      (en[8:4]),
    .day_num_i (day_num),
    .year_o    (year_o),
    .month_o   (month_o),
    .day_o     (day_o)
  );

  sctd_tod u_tod (
    .clk_i    (clk_i),
    .en_i     (en[8:4]),
    .sod_i    (sod),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

endmodule

`default_nettype wire

[rtl/core/sctd_checker.sv]
`default_nettype none

module sctd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [11:0] year_o,
  input logic [3:0]  month_o,
  input logic [4:0]  day_o,
  input logic [4:0]  hour_o,
  input logic [5:0]  minute_o,
  input logic [5:0]  second_o
);

  // A stalled result word stays valid, with its year, day and second unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(year_o) && $stable(day_o)
      && $stable(second_o))
    else $error("result word changed while stalled");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> month_o >= 4'd1 && month_o <= 4'd12)
    else $error("month out of range");

  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> day_o >= 5'd1 && (month_o != 4'd2 || day_o <= 5'd29)
      && year_o >= 12'd1970 && year_o <= 12'd2106)
    else $error("date out of range");

  a_tod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> hour_o <= 5'd23 && minute_o <= 6'd59 && second_o <= 6'd59)
    else $error("time of day out of range");

endmodule

bind seconds_to_calendar_date sctd_checker u_sctd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .year_o      (year_o),
  .month_o     (month_o),
  .day_o       (day_o),
  .hour_o      (hour_o),
  .minute_o    (minute_o),
  .second_o    (second_o)
);

`default_nettype wire
